// File: hdl/ccksb_pkg.sv
// ----------------------------------------------------------------------------
// ccksb_pkg
// Shared types, constants and register codes of the sprite blitter with
// clipping and colour key.
// ----------------------------------------------------------------------------
package ccksb_pkg;

  // Screen geometry.
  localparam int SCREEN_WIDTH    = 1024;
  localparam int SCREEN_HEIGHT   = 768;
  localparam int BYTES_PER_PIXEL = 3;

  // Field widths fixed by the interface.
  localparam int COLOR_W = 24;
  localparam int ADDR_W  = 32;
  localparam int CNT_W   = 10;
  localparam int SIZE_W  = 11;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 32;

  // Signed screen position: must hold the sprite offset plus a counter
  // and also the largest screen dimension.
  localparam int POS_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ?
                           ((SCREEN_WIDTH > 2048) ? SCREEN_WIDTH : 2048) :
                           ((SCREEN_HEIGHT > 2048) ? SCREEN_HEIGHT : 2048);
  localparam int POS_W   = $clog2(POS_MAX) + 1;

  // Linear pixel index inside the screen.
  localparam int IDX_W = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT);

  // Transparent key, bytes 0x80, 0x00, 0xff from low to high.
  localparam logic [7:0] KEY_BYTE0 = 8'h80;
  localparam logic [7:0] KEY_BYTE1 = 8'h00;
  localparam logic [7:0] KEY_BYTE2 = 8'hff;
  localparam logic [COLOR_W-1:0] KEY_COLOR = {KEY_BYTE2, KEY_BYTE1, KEY_BYTE0};

  // Largest counter value; also the wrap point for out-of-range sizes.
  localparam logic [CNT_W-1:0] CNT_LAST = {CNT_W{1'b1}};
  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(1024);

  // Configuration register indexes.
  typedef enum logic [CIDX_W-1:0] {
    REG_SPRITE_X      = 3'd0,
    REG_SPRITE_Y      = 3'd1,
    REG_SPRITE_WIDTH  = 3'd2,
    REG_SPRITE_HEIGHT = 3'd3,
    REG_FRAME_BASE    = 3'd4
  } reg_index_t;

  // Configuration register file contents.
  typedef struct packed {
    logic signed [SIZE_W-1:0] sprite_x;
    logic signed [SIZE_W-1:0] sprite_y;
    logic [SIZE_W-1:0]        sprite_width;
    logic [SIZE_W-1:0]        sprite_height;
    logic [ADDR_W-1:0]        frame_base;
  } cfg_t;

  // Sprite position of the pixel about to be accepted.
  typedef struct packed {
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] row;
  } pos_t;

  // Visible pixel handed from the clipping stage to the address stage.
  typedef struct packed {
    logic               valid;
    logic [COLOR_W-1:0] color;
    logic [IDX_W-1:0]   idx;
  } stage_t;

  // Last counter value before wrapping for a given sprite size.
  function automatic logic [CNT_W-1:0] last_index(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] dec;
    dec = size - SIZE_W'(1);
    if (size != '0 && size <= SIZE_MAX) begin
      last_index = dec[CNT_W-1:0];
    end else begin
      last_index = CNT_LAST;
    end
  endfunction

endpackage

// File: hdl/ccksb_cfg.sv
// ----------------------------------------------------------------------------
// ccksb_cfg
// Configuration register file; writes to indexes past the list are dropped.
// ----------------------------------------------------------------------------
module ccksb_cfg import ccksb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data,
  output cfg_t               cfg
);

  // The register file can always take a write.
  assign cfg_ready = 1'b1;

  // Register writes, one per beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sprite_x      <= '0;
      cfg.sprite_y      <= '0;
      cfg.sprite_width  <= SIZE_W'(1);
      cfg.sprite_height <= SIZE_W'(1);
      cfg.frame_base    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SPRITE_X:      cfg.sprite_x      <= $signed(cfg_data[SIZE_W-1:0]);
        REG_SPRITE_Y:      cfg.sprite_y      <= $signed(cfg_data[SIZE_W-1:0]);
        REG_SPRITE_WIDTH:  cfg.sprite_width  <= cfg_data[SIZE_W-1:0];
        REG_SPRITE_HEIGHT: cfg.sprite_height <= cfg_data[SIZE_W-1:0];
        REG_FRAME_BASE:    cfg.frame_base    <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/ccksb_cnt.sv
// ----------------------------------------------------------------------------
// ccksb_cnt
// Column and row counters that walk the sprite in raster order.
// ----------------------------------------------------------------------------
module ccksb_cnt import ccksb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  cfg_t cfg,
  output pos_t pos
);

  logic [CNT_W-1:0] last_col;
  logic [CNT_W-1:0] last_row;
  pos_t             pos_next;

  assign last_col = last_index(cfg.sprite_width);
  assign last_row = last_index(cfg.sprite_height);

  // Step to the next pixel, wrapping at the end of each row and of the sprite.
  always_comb begin
    pos_next = pos;
    if (pos.col == last_col) begin
      pos_next.col = '0;
      if (pos.row == last_row) begin
        pos_next.row = '0;
      end else begin
        pos_next.row = pos.row + CNT_W'(1);
      end
    end else begin
      pos_next.col = pos.col + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (advance) begin
      pos <= pos_next;
    end
  end

endmodule

// File: hdl/ccksb_clip.sv
// ----------------------------------------------------------------------------
// ccksb_clip
// Input register, screen clipping, colour-key test and pixel index.
// ----------------------------------------------------------------------------
module ccksb_clip import ccksb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COLOR_W-1:0] pixel_color,
  input  pos_t               pos,
  input  cfg_t               cfg,
  input  logic               down_ready,
  output stage_t             stage
);

  // Input register.
  logic               a_valid;
  logic [COLOR_W-1:0] a_color;
  pos_t               a_pos;

  logic               a_move;
  logic               b_move;
  logic signed [POS_W-1:0] sx;
  logic signed [POS_W-1:0] sy;
  logic               on_screen;
  logic               hit;
  logic [IDX_W-1:0]   idx;

  // Stage hand-off: each register moves when the one after it can.
  assign b_move   = !stage.valid || down_ready;
  assign a_move   = !a_valid || b_move;
  assign in_ready = a_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_move) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_move) begin
      a_color <= pixel_color;
      a_pos   <= pos;
    end
  end

  // Screen position and clipping against the screen rectangle.
  assign sx = POS_W'(cfg.sprite_x) + $signed({1'b0, (POS_W-1)'(a_pos.col)});
  assign sy = POS_W'(cfg.sprite_y) + $signed({1'b0, (POS_W-1)'(a_pos.row)});

  assign on_screen = !sx[POS_W-1] && ($unsigned(sx) < POS_W'(SCREEN_WIDTH)) &&
                     !sy[POS_W-1] && ($unsigned(sy) < POS_W'(SCREEN_HEIGHT));
  assign hit = on_screen && (a_color != KEY_COLOR);

  // Linear pixel index; only meaningful for a visible pixel.
  assign idx = IDX_W'(IDX_W'($unsigned(sy)) * IDX_W'(SCREEN_WIDTH)) +
               IDX_W'($unsigned(sx));

  // Clipped or keyed pixels are dropped here; the payload follows any beat
  // that moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (b_move) begin
      stage.valid <= a_valid && hit;
    end
    if (b_move && a_valid) begin
      stage.color <= a_color;
      stage.idx   <= idx;
    end
  end

endmodule

// File: hdl/ccksb_addr.sv
// ----------------------------------------------------------------------------
// ccksb_addr
// Byte address forming and the output register.
// ----------------------------------------------------------------------------
module ccksb_addr import ccksb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  stage_t             stage,
  input  cfg_t               cfg,
  output logic               up_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ADDR_W-1:0]  fb_address,
  output logic [COLOR_W-1:0] write_color
);

  logic [ADDR_W-1:0] addr;

  // The output register takes a beat when empty or when its beat leaves.
  assign up_ready = !out_valid || !out_stall;

  // Base plus pixel index times bytes per pixel, modulo 2^32.
  assign addr = cfg.frame_base + ADDR_W'(ADDR_W'(stage.idx) * ADDR_W'(BYTES_PER_PIXEL));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && stage.valid) begin
      fb_address  <= addr;
      write_color <= stage.color;
    end
  end

endmodule

// File: hdl/clipped_color_key_sprite_blit_top.sv
// ----------------------------------------------------------------------------
// clipped_color_key_sprite_blit_top
// Sprite blitter with screen clipping and a transparent colour key.
// ----------------------------------------------------------------------------
// Usage:
// Sprite pixels enter on the input channel (in_valid, in_stall, pixel_color)
// in raster order, one beat per pixel; the block counts column and row
// itself and wraps to the top left after the last pixel of the sprite.
// Each visible, non-transparent pixel leaves on the output channel
// (out_valid, out_stall, fb_address, write_color); clipped pixels and the
// key colour produce no output beat but still advance the counters.
// Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data;
// the user must write them only while no pixel is in flight, which the
// block itself does not enforce; cfg_ready is always high. Throughput is
// one pixel per cycle while the receiver does not stall. An accepted input
// beat passes the input register, the clipping and index stage and the
// output register in that order.
// When the receiver stalls, the three registers fill and then in_stall
// rises; no beat is lost. Reset empties the pipeline, clears the counters
// and sets position 0,0, size 1x1 and frame base 0.
// ----------------------------------------------------------------------------
module clipped_color_key_sprite_blit_top import ccksb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [COLOR_W-1:0] pixel_color,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ADDR_W-1:0]  fb_address,
  output logic [COLOR_W-1:0] write_color,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data
);

  cfg_t   cfg;
  pos_t   pos;
  stage_t stage;
  logic   in_ready;
  logic   down_ready;
  logic   in_take;

  assign in_stall = !in_ready;
  assign in_take  = in_valid && in_ready;

  // Register file.
  ccksb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Raster counters, stepping on every accepted pixel.
  ccksb_cnt u_cnt (
    .clk     (clk),
    .rst     (rst),
    .advance (in_take),
    .cfg     (cfg),
    .pos     (pos)
  );

  // Input register and clipping stage.
  ccksb_clip u_clip (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_color (pixel_color),
    .pos         (pos),
    .cfg         (cfg),
    .down_ready  (down_ready),
    .stage       (stage)
  );

  // Address stage and output register.
  ccksb_addr u_addr (
    .clk         (clk),
    .rst         (rst),
    .stage       (stage),
    .cfg         (cfg),
    .up_ready    (down_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .fb_address  (fb_address),
    .write_color (write_color)
  );

  // A full, stalled pipeline must hold the input off.
  a_full_stall : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && stage.valid && u_clip.a_valid) |-> in_stall)
    else $error("pipeline full and stalled but input not held off");

  // The column counter wraps after the last column of the sprite.
  a_col_wrap : assert property (@(posedge clk) disable iff (rst)
    (in_take && pos.col == last_index(cfg.sprite_width)) |=> (pos.col == '0))
    else $error("column counter did not wrap at the sprite edge");

  // An output beat only appears from a visible pixel in the index stage.
  a_out_source : assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid)) |-> $past(stage.valid))
    else $error("output beat without a visible pixel behind it");

endmodule
